>>> rtl/core/sps_pkg.sv
// ----------------------------------------------------------------------------
// Scheduler package
// Shared types, constants and the helper function of the priority scheduler.
// ----------------------------------------------------------------------------
package sps_pkg;

  localparam int SEM_COUNT   = 16;
  localparam int SEM_IDX_W   = $clog2(SEM_COUNT);
  localparam int PRIO_LEVELS = 32;

  localparam logic signed [15:0] LEVEL_MIN = 16'sh8000;
  localparam logic signed [15:0] LEVEL_MAX = 16'sh7fff;

  // Reciprocal of ten scaled by 2**35; exact for every 32-bit dividend.
  localparam logic [31:0] RECIP_TEN   = 32'hcccc_cccd;
  localparam int          RECIP_SHIFT = 35;

  typedef enum logic [2:0] {
    OP_REGISTER = 3'd0,
    OP_WAIT     = 3'd1,
    OP_TRY      = 3'd2,
    OP_SIGNAL   = 3'd3,
    OP_SCHEDULE = 3'd4
  } op_e;

  typedef struct packed {
    logic [2:0]  operation;
    logic [4:0]  task_priority;
    logic [4:0]  current_priority;
    logic [3:0]  sem_id;
    logic [31:0] timeout_ticks;
    logic [14:0] signal_amount;
  } sps_in_t;

  typedef struct packed {
    logic [4:0]  ready_priority;
    logic [31:0] ready_bits;
    logic        caller_blocked;
    logic        try_success;
    logic [28:0] timer_value;
    logic        switch_request;
  } sps_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic commit;
  } sps_cmd_t;

  // Lowest set bit by a five-step binary search; an empty map gives 31.
  function automatic logic [4:0] lowest_ready(logic [31:0] map);
    logic [31:0] m;
    logic [4:0]  p;
    m = map;
    p = '0;
    if (m[15:0] == 16'h0) begin
      m    = m >> 16;
      p[4] = 1'b1;
    end
    if (m[7:0] == 8'h0) begin
      m    = m >> 8;
      p[3] = 1'b1;
    end
    if (m[3:0] == 4'h0) begin
      m    = m >> 4;
      p[2] = 1'b1;
    end
    if (m[1:0] == 2'h0) begin
      m    = m >> 2;
      p[1] = 1'b1;
    end
    if (m[0] == 1'b0) begin
      p[0] = 1'b1;
    end
    return p;
  endfunction

endpackage

>>> rtl/core/sps_ctrl.sv
// ----------------------------------------------------------------------------
// Scheduler controller
// Two-state sequencer that takes one transaction, lets the datapath execute it
// and keeps the output register's valid flag.
// ----------------------------------------------------------------------------
module sps_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sps_pkg::sps_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // The output register can be loaded when empty or when it is being emptied.
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d       = state_q;
    out_valid_d   = out_valid_q;
    cmd_o.load_in = 1'b0;
    cmd_o.commit  = 1'b0;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  a_commit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (!out_valid_q || !out_stall_i))
    else $error("result committed over an unread result");

  a_accept_then_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_in |=> (state_q == S_EXEC))
    else $error("accepted transaction did not enter execution");

  a_commit_gives_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> (out_valid_q && (state_q == S_IDLE)))
    else $error("committed result not presented");

endmodule

>>> rtl/core/sps_datapath.sv
// ----------------------------------------------------------------------------
// Scheduler datapath
// Ready bitmap, chosen priority, semaphore table, input and output registers,
// and the read-modify-write logic of one operation.
// ----------------------------------------------------------------------------
module sps_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sps_pkg::sps_cmd_t cmd_i,
  input  sps_pkg::sps_in_t  in_data_i,
  output sps_pkg::sps_out_t out_data_o
);

  sps_pkg::sps_in_t  in_q;
  sps_pkg::sps_out_t out_q, out_d;

  logic [31:0]        ready_map_q, ready_map_d;
  logic [4:0]         chosen_q, chosen_d;
  logic signed [15:0] level_q [sps_pkg::SEM_COUNT];
  logic [4:0]         waiter_q [sps_pkg::SEM_COUNT];
  logic               wvalid_q [sps_pkg::SEM_COUNT];

  logic [sps_pkg::SEM_IDX_W-1:0] sid;
  logic                          sem_ok;
  logic signed [15:0]            lvl, lvl_dec, lvl_d;
  logic signed [16:0]            sum;
  logic [4:0]                    waiter_d;
  logic                          wvalid_d;
  logic                          sem_wr;
  logic [63:0]                   product;
  logic [31:0]                   blocked_map;

  assign sid     = in_q.sem_id[sps_pkg::SEM_IDX_W-1:0];
  assign sem_ok  = 32'(in_q.sem_id) < 32'(sps_pkg::SEM_COUNT);
  assign lvl     = level_q[sid];
  assign lvl_dec = (lvl != sps_pkg::LEVEL_MIN) ? lvl - 16'sd1 : lvl;
  assign sum     = {lvl[15], lvl} + {2'b00, in_q.signal_amount};
  assign product = 64'(in_q.timeout_ticks) * 64'(sps_pkg::RECIP_TEN);
  assign blocked_map = ready_map_q & ~(32'h1 << in_q.current_priority);

  always_comb begin
    ready_map_d = ready_map_q;
    chosen_d    = chosen_q;
    lvl_d       = lvl;
    waiter_d    = waiter_q[sid];
    wvalid_d    = wvalid_q[sid];
    sem_wr      = 1'b0;
    out_d       = '0;
    unique case (in_q.operation)
      sps_pkg::OP_REGISTER: begin
        ready_map_d = ready_map_q | (32'h1 << in_q.task_priority);
      end
      sps_pkg::OP_WAIT: begin
        if (sem_ok) begin
          sem_wr            = 1'b1;
          lvl_d             = lvl_dec;
          out_d.timer_value = product[63:sps_pkg::RECIP_SHIFT];
          if (lvl_dec[15]) begin
            waiter_d             = in_q.current_priority;
            wvalid_d             = 1'b1;
            ready_map_d          = blocked_map;
            chosen_d             = sps_pkg::lowest_ready(blocked_map);
            out_d.caller_blocked = 1'b1;
            out_d.switch_request = 1'b1;
          end
        end
      end
      sps_pkg::OP_TRY: begin
        if (sem_ok && !lvl[15] && (lvl != 16'sd0)) begin
          sem_wr            = 1'b1;
          lvl_d             = lvl - 16'sd1;
          out_d.try_success = 1'b1;
        end
      end
      sps_pkg::OP_SIGNAL: begin
        if (sem_ok) begin
          sem_wr = 1'b1;
          // Positive overflow past the top of the level saturates.
          lvl_d  = (!sum[16] && sum[15]) ? sps_pkg::LEVEL_MAX : sum[15:0];
          if (!lvl_d[15] && wvalid_q[sid]) begin
            ready_map_d = ready_map_q | (32'h1 << waiter_q[sid]);
            wvalid_d    = 1'b0;
            if (waiter_q[sid] < chosen_q) begin
              chosen_d = waiter_q[sid];
            end
          end
        end
      end
      sps_pkg::OP_SCHEDULE: begin
        chosen_d             = sps_pkg::lowest_ready(ready_map_q);
        out_d.switch_request = 1'b1;
      end
      default: begin
      end
    endcase
    out_d.ready_priority = chosen_d;
    out_d.ready_bits     = ready_map_d;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_q <= in_data_i;
    end
    if (cmd_i.commit) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_map_q <= '0;
      chosen_q    <= '0;
      for (int i = 0; i < sps_pkg::SEM_COUNT; i++) begin
        level_q[i]  <= '0;
        waiter_q[i] <= '0;
        wvalid_q[i] <= 1'b0;
      end
    end else if (cmd_i.commit) begin
      ready_map_q <= ready_map_d;
      chosen_q    <= chosen_d;
      if (sem_wr) begin
        level_q[sid]  <= lvl_d;
        waiter_q[sid] <= waiter_d;
        wvalid_q[sid] <= wvalid_d;
      end
    end
  end

  assign out_data_o = out_q;

  a_blocked_clears_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && out_d.caller_blocked)
      |=> !ready_map_q[$past(in_q.current_priority)])
    else $error("blocked caller is still marked ready");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> !(out_d.caller_blocked && out_d.try_success))
    else $error("wait and try flags raised together");

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.commit |=> ($stable(ready_map_q) && $stable(chosen_q)))
    else $error("scheduler state changed outside a commit");

endmodule

>>> rtl/core/semaphore_priority_scheduler_unit.sv
// ----------------------------------------------------------------------------
// Semaphore priority scheduler unit
// Kernel helper with a ready bitmap, a chosen ready priority and counting
// semaphores with one waiting task each.
// ----------------------------------------------------------------------------
// Usage: an operation is offered on in_data_i with in_valid_i and is taken in
// a cycle where in_stall_o is low. Exactly one result per transaction appears
// on out_data_o with out_valid_o and is taken when out_stall_i is low.
// An accepted operation is first registered in the input register; then, in
// the execute state, the addressed semaphore entry, the bitmap and the chosen
// priority are read, modified and written, and the output register is loaded.
// No new transaction is taken until this single read-modify-write pass over
// the scheduler state is done; in_stall_o is high during the execute state.
// The output register lets a new transaction be taken while a result still
// waits. If the receiver stalls, the next transaction is held in the execute
// state until the output register frees, so results are never overwritten.
// Reset clears the bitmap, the chosen priority and every semaphore level,
// waiter and valid flag at once; the block can take a transaction as soon
// as reset is released.
// ----------------------------------------------------------------------------
module semaphore_priority_scheduler_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sps_pkg::sps_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sps_pkg::sps_out_t out_data_o
);

  sps_pkg::sps_cmd_t cmd;

  sps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  sps_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

  a_block_requests_switch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.caller_blocked) |-> out_data_o.switch_request)
    else $error("blocking wait without switch request");

  a_accept_then_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second transaction accepted during execution");

  a_blocked_prio_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.caller_blocked && (out_data_o.ready_bits != 32'h0))
      |-> out_data_o.ready_bits[out_data_o.ready_priority])
    else $error("rescheduled priority is not ready");

endmodule
